[rtl/rgbbam_pkg.sv]
// Shared types, constants and helpers for the RGB matrix BAM scanner.
`default_nettype none
package rgbbam_pkg;

   localparam int ROWS    = 6;
   localparam int COLUMNS = 5;

   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;
   localparam int CNT_W   = 7;
   localparam int HOLD_W  = 8;
   localparam int COLOR_W = 8;
   localparam int NIB_W   = 4;
   localparam int PLANE_W = 2;
   localparam int WORD_W  = 24;

   // Shift word layout
   localparam int RED_LSB   = 6;
   localparam int GREEN_LSB = 11;
   localparam int BLUE_LSB  = 16;

   // Operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_PIXEL = 2'd1;
   localparam logic [1:0] OP_HOLD  = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_PLANE0_END  = 2'd0;
   localparam logic [1:0] REG_PLANE1_END  = 2'd1;
   localparam logic [1:0] REG_PLANE2_END  = 2'd2;
   localparam logic [1:0] REG_SCAN_PERIOD = 2'd3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]  PLANE0_END_RESET  = 7'd6;
   localparam logic [CNT_W-1:0]  PLANE1_END_RESET  = 7'd18;
   localparam logic [CNT_W-1:0]  PLANE2_END_RESET  = 7'd42;
   localparam logic [CNT_W-1:0]  SCAN_PERIOD_RESET = 7'd90;
   localparam logic [HOLD_W-1:0] HOLD_RESET        = 8'd3;

   typedef struct packed {
      logic [NIB_W-1:0] red;
      logic [NIB_W-1:0] green;
      logic [NIB_W-1:0] blue;
   } pixel_type;

   typedef pixel_type [COLUMNS-1:0] row_pixels_type;

   typedef struct packed {
      logic [CNT_W-1:0] plane0_end;
      logic [CNT_W-1:0] plane1_end;
      logic [CNT_W-1:0] plane2_end;
      logic [CNT_W-1:0] scan_period;
   } scan_cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [PLANE_W-1:0] plane;
      logic               clear;
      logic               hold_zero;
   } scan_status_type;

   // v*15/255 without a divider: take v*15/256, then correct by one step
   function automatic logic [NIB_W-1:0] to_nibble(input logic [COLOR_W-1:0] v);
      logic [11:0]      prod;
      logic [11:0]      rem;
      logic [NIB_W-1:0] q;
      prod = {v, 4'b0000} - {4'b0000, v};
      q    = prod[11:8];
      rem  = prod - ({q, 8'h00} - {8'h00, q});
      if (rem >= 12'd255) begin
         q = q + 4'd1;
      end
      return q;
   endfunction

endpackage
`default_nettype wire

[rtl/rgb_matrix_bam_scanner_top.sv]
// rsp_valid is registered; a tick beat passes the input register, then the result one.
// Throughput: one item per cycle unless a tick waits on a stalled result side; pixel
// and hold beats never wait on it. The rate is set by the single input register
// feeding the result register. Synchronous active-high reset clears the frame store,
// sets counters and config registers to reset values; no clearing pass follows.
`default_nettype none
module rgb_matrix_bam_scanner_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic [rgbbam_pkg::ROW_W-1:0]         req_row,
   input  logic [rgbbam_pkg::COL_W-1:0]         req_column,
   input  logic [rgbbam_pkg::COLOR_W-1:0]       req_red,
   input  logic [rgbbam_pkg::COLOR_W-1:0]       req_green,
   input  logic [rgbbam_pkg::COLOR_W-1:0]       req_blue,
   input  logic [rgbbam_pkg::HOLD_W-1:0]        req_hold_periods,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rgbbam_pkg::WORD_W-1:0]        rsp_shift_word,
   output logic [rgbbam_pkg::ROW_W-1:0]         rsp_row_index,
   output logic [rgbbam_pkg::PLANE_W-1:0]       rsp_bit_plane,
   output logic                                 rsp_frame_cleared,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rgbbam_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rgbbam_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rgbbam_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import rgbbam_pkg::*;

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic [1:0]         op_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [COLOR_W-1:0] red_ff, green_ff, blue_ff;
   logic [HOLD_W-1:0]  hold_ff;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]  word_ff;
   logic [ROW_W-1:0]   out_row_ff;
   logic [PLANE_W-1:0] out_plane_ff;
   logic               out_clear_ff;

   scan_cfg_type       cfg;
   scan_status_type    status;
   row_pixels_type     rd_pixels;
   pixel_type          wr_pixel;
   logic               is_tick;
   logic               out_free;
   logic               fire;
   logic               tick;
   logic               pix_wr;
   logic               in_load;
   logic [WORD_W-1:0]  word;

   assign is_tick   = (op_ff == OP_TICK);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!is_tick || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign in_load   = req_valid && !req_stall;
   assign tick      = fire && is_tick;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_free ? tick : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         op_ff    <= req_operation;
         row_ff   <= req_row;
         col_ff   <= req_column;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         hold_ff  <= req_hold_periods;
      end
   end

   rgbbam_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rgbbam_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .tick       (tick),
      .hold_load  (fire && op_ff == OP_HOLD),
      .hold_value (hold_ff),
      .status     (status)
   );

   // Drop writes while the frame is held or the pixel lies off the matrix
   assign pix_wr = fire && (op_ff == OP_PIXEL) && status.hold_zero
                   && (row_ff < ROW_W'(ROWS)) && (col_ff < COL_W'(COLUMNS));

   assign wr_pixel.red   = to_nibble(red_ff);
   assign wr_pixel.green = to_nibble(green_ff);
   assign wr_pixel.blue  = to_nibble(blue_ff);

   rgbbam_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (pix_wr),
      .wr_row    (row_ff),
      .wr_col    (col_ff),
      .wr_pixel  (wr_pixel),
      .clear     (tick && status.clear),
      .rd_row    (status.row),
      .rd_pixels (rd_pixels)
   );

   // Word comes from the store as it stands before this tick's clear
   always_comb begin
      word = '0;
      for (int r = 0; r < ROWS; r++) begin
         word[r] = (status.row == ROW_W'(r));
      end
      for (int c = 0; c < COLUMNS; c++) begin
         word[RED_LSB + c]   = rd_pixels[c].red[status.plane];
         word[GREEN_LSB + c] = rd_pixels[c].green[status.plane];
         word[BLUE_LSB + c]  = rd_pixels[c].blue[status.plane];
      end
   end

   always_ff @(posedge clock) begin
      if (tick && out_free) begin
         word_ff      <= word;
         out_row_ff   <= status.row;
         out_plane_ff <= status.plane;
         out_clear_ff <= status.clear;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_shift_word    = word_ff;
   assign rsp_row_index     = out_row_ff;
   assign rsp_bit_plane     = out_plane_ff;
   assign rsp_frame_cleared = out_clear_ff;

endmodule
`default_nettype wire

[rtl/rgbbam_csr.sv]
// Configuration registers for the scanner: plane ends and scan period.
`default_nettype none
module rgbbam_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rgbbam_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rgbbam_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rgbbam_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output rgbbam_pkg::scan_cfg_type             cfg
);
   import rgbbam_pkg::*;

   scan_cfg_type     cfg_ff;
   scan_cfg_type     cfg_in;
   logic             wr_en;
   logic [1:0]       reg_sel;
   logic [CNT_W-1:0] rd_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_PLANE0_END:  cfg_in.plane0_end  = csr_pwdata[CNT_W-1:0];
            REG_PLANE1_END:  cfg_in.plane1_end  = csr_pwdata[CNT_W-1:0];
            REG_PLANE2_END:  cfg_in.plane2_end  = csr_pwdata[CNT_W-1:0];
            REG_SCAN_PERIOD: cfg_in.scan_period = csr_pwdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane0_end  <= PLANE0_END_RESET;
         cfg_ff.plane1_end  <= PLANE1_END_RESET;
         cfg_ff.plane2_end  <= PLANE2_END_RESET;
         cfg_ff.scan_period <= SCAN_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PLANE0_END:  rd_val = cfg_ff.plane0_end;
         REG_PLANE1_END:  rd_val = cfg_ff.plane1_end;
         REG_PLANE2_END:  rd_val = cfg_ff.plane2_end;
         REG_SCAN_PERIOD: rd_val = cfg_ff.scan_period;
         default:         rd_val = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, rd_val};
   assign cfg        = cfg_ff;

endmodule
`default_nettype wire

[rtl/rgbbam_frame.sv]
// Frame store: per-pixel OR writes, whole-store clear, one row read port.
`default_nettype none
module rgbbam_frame (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [rgbbam_pkg::ROW_W-1:0]       wr_row,
   input  logic [rgbbam_pkg::COL_W-1:0]       wr_col,
   input  rgbbam_pkg::pixel_type              wr_pixel,
   input  logic                               clear,
   input  logic [rgbbam_pkg::ROW_W-1:0]       rd_row,
   output rgbbam_pkg::row_pixels_type         rd_pixels
);
   import rgbbam_pkg::*;

   row_pixels_type [ROWS-1:0] store_ff;
   row_pixels_type [ROWS-1:0] store_in;

   always_comb begin
      store_in = store_ff;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            if (clear) begin
               store_in[r][c] = '0;
            end else if (wr_en && wr_row == ROW_W'(r) && wr_col == COL_W'(c)) begin
               store_in[r][c] = store_ff[r][c] | wr_pixel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else begin
         store_ff <= store_in;
      end
   end

   always_comb begin
      rd_pixels = '0;
      for (int r = 0; r < ROWS; r++) begin
         if (rd_row == ROW_W'(r)) begin
            rd_pixels = store_ff[r];
         end
      end
   end

endmodule
`default_nettype wire

[rtl/rgbbam_scan.sv]
// Scan sequencer: row counter, plane counter, hold countdown and clear decision.
`default_nettype none
module rgbbam_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  rgbbam_pkg::scan_cfg_type            cfg,
   input  logic                                tick,
   input  logic                                hold_load,
   input  logic [rgbbam_pkg::HOLD_W-1:0]       hold_value,
   output rgbbam_pkg::scan_status_type         status
);
   import rgbbam_pkg::*;

   logic [ROW_W-1:0]  row_ff,  row_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [CNT_W:0]    cnt_next;
   logic              wrap;
   logic [HOLD_W-1:0] hold_dec;
   logic [PLANE_W-1:0] plane;

   always_comb begin
      if (cnt_ff <= cfg.plane0_end) begin
         plane = 2'd0;
      end else if (cnt_ff <= cfg.plane1_end) begin
         plane = 2'd1;
      end else if (cnt_ff <= cfg.plane2_end) begin
         plane = 2'd2;
      end else begin
         plane = 2'd3;
      end
   end

   // 8-bit compare also covers overflow past 127
   assign cnt_next = {1'b0, cnt_ff} + 1'b1;
   assign wrap     = (cnt_next >= {1'b0, cfg.scan_period}) || cnt_next[CNT_W];
   assign hold_dec = (hold_ff != '0) ? hold_ff - 1'b1 : hold_ff;

   always_comb begin
      row_in  = row_ff;
      cnt_in  = cnt_ff;
      hold_in = hold_ff;
      if (tick) begin
         row_in = (row_ff >= ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
         if (wrap) begin
            cnt_in  = CNT_W'(1);
            hold_in = hold_dec;
         end else begin
            cnt_in = cnt_next[CNT_W-1:0];
         end
      end else if (hold_load) begin
         hold_in = hold_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         cnt_ff  <= CNT_W'(1);
         hold_ff <= HOLD_RESET;
      end else begin
         row_ff  <= row_in;
         cnt_ff  <= cnt_in;
         hold_ff <= hold_in;
      end
   end

   assign status.row       = row_ff;
   assign status.plane     = plane;
   assign status.clear     = wrap && (hold_dec == '0);
   assign status.hold_zero = (hold_ff == '0);

endmodule
`default_nettype wire
